[rtl/pirt_pkg.sv]
// Package: shared types, constants and codes of the PCI INTx route table.
`timescale 1ns / 1ps
`default_nettype none
package pirt_pkg;

  // Table depth default
  localparam int ROUTE_ENTRIES_DEF = 32;

  // Configuration register reset values
  localparam logic [31:0] ADDRESS_MASK_RESET = 32'h0000_1800;
  localparam logic [7:0]  PIN_MASK_RESET     = 8'h07;

  // Highest legal interrupt pin (INTD)
  localparam logic [7:0] PIN_MAX = 8'd4;

  // Width of the configuration register index
  localparam int CFG_INDEX_W = 8;

  // Item kinds
  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ADDRESS_MASK = 8'd0,
    REG_PIN_MASK     = 8'd1
  } reg_index_t;

  // Current masks handed from the top level to the controller
  typedef struct packed {
    logic [31:0] address_mask;
    logic [7:0]  pin_mask;
  } cfg_t;

  // One stored route
  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  pin;
    logic [31:0] irq;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

endpackage
`default_nettype wire

[rtl/pirt_if.sv]
// Interfaces: input, result and configuration channels of the route table.
`timescale 1ns / 1ps
`default_nettype none
interface pirt_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  operation;
  logic [31:0] child_address;
  logic [7:0]  bus_number;
  logic [4:0]  device_number;
  logic [2:0]  function_number;
  logic [7:0]  pin;
  logic [31:0] irq_number;

  modport source (
    output valid, operation, child_address, bus_number, device_number,
           function_number, pin, irq_number,
    input  ready
  );
  modport sink (
    input  valid, operation, child_address, bus_number, device_number,
           function_number, pin, irq_number,
    output ready
  );
endinterface

interface pirt_out_if;
  logic        valid;
  logic        ready;
  logic [0:0]  accepted;
  logic [31:0] found_irq;

  modport source (output valid, accepted, found_irq, input ready);
  modport sink (input valid, accepted, found_irq, output ready);
endinterface

interface pirt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pirt_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/pirt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pirt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/pirt_ctrl.sv]
// Controller: stores routes, scans the route memory for lookups, holds the result.
`timescale 1ns / 1ps
`default_nettype none
module pirt_ctrl #(
  parameter int ROUTE_ENTRIES = pirt_pkg::ROUTE_ENTRIES_DEF,
  parameter int ADDR_W        = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1,
  parameter int CNT_W         = $clog2(ROUTE_ENTRIES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pirt_pkg::cfg_t                cfg,
  pirt_in_if.sink                            in_ch,
  pirt_out_if.source                         out_ch,
  output logic                               mem_we,
  output logic      [ADDR_W-1:0]             mem_waddr,
  output pirt_pkg::route_entry_t             mem_wdata,
  output logic                               mem_re,
  output logic      [ADDR_W-1:0]             mem_raddr,
  input  wire pirt_pkg::route_entry_t        mem_rdata
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ROUTE_ENTRIES);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [31:0]        key_addr_r, key_addr_nxt;
  logic [7:0]         key_pin_r, key_pin_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_accepted_r, out_accepted_nxt;
  logic [31:0]        out_irq_r, out_irq_nxt;

  logic               in_fire;
  logic               add_ok;
  logic               hit;
  logic [31:0]        lookup_addr;

  assign in_ch.ready      = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.accepted  = out_accepted_r;
  assign out_ch.found_irq = out_irq_r;

  // Legal pin, nonzero interrupt and room left
  assign add_ok = (in_ch.pin != 8'd0) && (in_ch.pin <= pirt_pkg::PIN_MAX) &&
                  (in_ch.irq_number != 32'd0) && (count_r < FULL_COUNT);

  // Address word of the function being looked up
  assign lookup_addr = {8'd0, in_ch.bus_number, in_ch.device_number,
                        in_ch.function_number, 8'd0};

  // Write the new route at the fill position
  assign mem_we            = in_fire && (in_ch.operation == pirt_pkg::OP_ADD) && add_ok;
  assign mem_waddr         = count_r[ADDR_W-1:0];
  assign mem_wdata.address = in_ch.child_address & cfg.address_mask;
  assign mem_wdata.pin     = in_ch.pin & cfg.pin_mask;
  assign mem_wdata.irq     = in_ch.irq_number;

  // Scan reads one entry a cycle; the entry read last cycle is compared now
  assign mem_re    = (state_r == ST_SCAN) && (idx_r < count_r);
  assign mem_raddr = idx_r[ADDR_W-1:0];
  assign hit       = pend_r && (mem_rdata.address == key_addr_r) &&
                     (mem_rdata.pin == key_pin_r);

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    idx_nxt          = idx_r;
    pend_nxt         = pend_r;
    key_addr_nxt     = key_addr_r;
    key_pin_nxt      = key_pin_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_accepted_nxt = out_accepted_r;
    out_irq_nxt      = out_irq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == pirt_pkg::OP_ADD) begin
            // Add: answer at once
            out_valid_nxt    = 1'b1;
            out_accepted_nxt = add_ok;
            out_irq_nxt      = 32'd0;
            if (add_ok) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            // Lookup: latch the masked key and start the scan
            key_addr_nxt = lookup_addr & cfg.address_mask;
            key_pin_nxt  = in_ch.pin & cfg.pin_mask;
            idx_nxt      = '0;
            pend_nxt     = 1'b0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        idx_nxt  = mem_re ? idx_r + CNT_W'(1) : idx_r;
        pend_nxt = mem_re;
        if (hit) begin
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = 1'b0;
          out_irq_nxt      = mem_rdata.irq;
          pend_nxt         = 1'b0;
          state_nxt        = ST_IDLE;
        end else if (!pend_r && !mem_re) begin
          // All stored entries checked, no route
          out_valid_nxt    = 1'b1;
          out_accepted_nxt = 1'b0;
          out_irq_nxt      = 32'd0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_addr_r     <= key_addr_nxt;
    key_pin_r      <= key_pin_nxt;
    out_accepted_r <= out_accepted_nxt;
    out_irq_r      <= out_irq_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE) && (count_r < FULL_COUNT))
    else $error("route write outside idle or into full table");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_ch.ready && !out_valid_r)
    else $error("input taken or result pending during scan");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_accepted_r && (out_irq_r != 32'd0)))
    else $error("result carries both add status and an interrupt");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> $stable(count_r))
    else $error("entry count changed during scan");
`endif

endmodule
`default_nettype wire

[rtl/pci_intx_route_table.sv]
// Top level: PCI INTx route table with configuration registers and route memory.
// Add item: result registered at acceptance; a new item can follow each cycle while
//   the result side takes results. Lookup item: the scan reads one route memory
//   entry per cycle until a match or the last stored entry; input held meanwhile.
// Reset: entry count cleared, masks return to 0x1800 and 0x7; route memory
//   is not cleared, entries at or above the count are never read.
`timescale 1ns / 1ps
`default_nettype none
module pci_intx_route_table #(
  parameter int ROUTE_ENTRIES = pirt_pkg::ROUTE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pirt_in_if.sink     in_ch,
  pirt_out_if.source  out_ch,
  pirt_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ROUTE_ENTRIES + 1);

  pirt_pkg::cfg_t          cfg_r;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  pirt_pkg::route_entry_t  mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  pirt_pkg::route_entry_t  mem_rdata;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_mask <= pirt_pkg::ADDRESS_MASK_RESET;
      cfg_r.pin_mask     <= pirt_pkg::PIN_MASK_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      priority if (cfg_ch.index == pirt_pkg::REG_ADDRESS_MASK) begin
        cfg_r.address_mask <= cfg_ch.data;
      end else if (cfg_ch.index == pirt_pkg::REG_PIN_MASK) begin
        cfg_r.pin_mask <= cfg_ch.data[7:0];
      end
    end
  end

  pirt_ctrl #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES),
    .ADDR_W        (ADDR_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pirt_ram #(
    .WIDTH  (pirt_pkg::ENTRY_W),
    .DEPTH  (ROUTE_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_route_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

[test/pci_intx_route_table_tb.sv]
// Self-checking testbench for the PCI INTx route table: random and directed adds and lookups.
`timescale 1ns / 1ps
module pci_intx_route_table_tb;
  import pirt_pkg::*;

  localparam int TABLE_DEPTH     = ROUTE_ENTRIES_DEF;
  localparam int IDLE_PERCENT    = 23;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = TABLE_DEPTH + 8;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int TARGET_LOG_MAX  = 96;

  // Register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 8'hFF;

  typedef struct {
    op_t         operation;
    logic [31:0] child_address;
    logic [7:0]  bus;
    logic [4:0]  dev;
    logic [2:0]  fn;
    logic [7:0]  pin;
    logic [31:0] irq;
  } route_req_t;

  typedef struct {
    logic        accepted;
    logic [31:0] found_irq;
  } route_resp_t;

  logic clk;
  logic rst_n;

  pirt_in_if  in_ch ();
  pirt_out_if out_ch ();
  pirt_cfg_if cfg_ch ();

  pci_intx_route_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Stimulus and scoreboard storage
  route_req_t  pending_requests[$];
  route_resp_t expected_routes[$];
  route_req_t  target_log[$];

  // Shadow copy of the table and its masks
  logic [31:0] shadow_address[TABLE_DEPTH];
  logic [7:0]  shadow_pin[TABLE_DEPTH];
  logic [31:0] shadow_irq[TABLE_DEPTH];
  int          shadow_count;
  logic [31:0] shadow_address_mask;
  logic [7:0]  shadow_pin_mask;

  bit quiet_mode;
  bit hold_off_start;
  int error_count;
  int items_sent;
  int adds_stored;
  int lookups_seen;
  int lookups_routed;
  int mask_settings;
  int cycle_count;

  // Compute the result of one item and update the shadow table
  function automatic route_resp_t predict_route(route_req_t r);
    route_resp_t resp;
    logic [31:0] key;
    logic [7:0]  key_pin;
    resp.accepted  = 1'b0;
    resp.found_irq = '0;
    if (r.operation == OP_ADD) begin
      if (r.pin >= 8'd1 && r.pin <= PIN_MAX && r.irq != '0 && shadow_count < TABLE_DEPTH) begin
        shadow_address[shadow_count] = r.child_address & shadow_address_mask;
        shadow_pin[shadow_count]     = r.pin & shadow_pin_mask;
        shadow_irq[shadow_count]     = r.irq;
        shadow_count++;
        resp.accepted = 1'b1;
      end
    end else begin
      key     = {8'h00, r.bus, r.dev, r.fn, 8'h00} & shadow_address_mask;
      key_pin = r.pin & shadow_pin_mask;
      for (int i = 0; i < shadow_count; i++) begin
        if (shadow_address[i] == key && shadow_pin[i] == key_pin) begin
          resp.found_irq = shadow_irq[i];
          break;
        end
      end
    end
    return resp;
  endfunction

  function automatic route_req_t make_add(logic [31:0] addr, logic [7:0] pin, logic [31:0] irq);
    route_req_t r;
    r = '{OP_ADD, addr, 8'h00, 5'h00, 3'h0, pin, irq};
    return r;
  endfunction

  function automatic route_req_t make_lookup(logic [7:0] bus, logic [4:0] dev, logic [2:0] fn,
                                            logic [7:0] pin);
    route_req_t r;
    r = '{OP_LOOKUP, 32'h0, bus, dev, fn, pin, 32'h0};
    return r;
  endfunction

  // Build one random item; lookups mostly aim at functions that were added
  function automatic route_req_t random_request(int add_percent);
    route_req_t r;
    route_req_t t;
    r.operation     = ($urandom_range(99) < add_percent) ? OP_ADD : OP_LOOKUP;
    r.child_address = $urandom;
    r.bus           = 8'($urandom);
    r.dev           = 5'($urandom);
    r.fn            = 3'($urandom);
    r.pin           = 8'($urandom);
    r.irq           = $urandom;
    if (r.operation == OP_ADD) begin
      if ($urandom_range(99) < 70) begin
        r.child_address[31:24] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        r.child_address[7:0]   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
      end
      if ($urandom_range(99) < 80) r.pin = 8'($urandom_range(1, 4));
      if ($urandom_range(99) < 8) r.irq = '0;
      t     = r;
      t.bus = r.child_address[23:16];
      t.dev = r.child_address[15:11];
      t.fn  = r.child_address[10:8];
      if (target_log.size() < TARGET_LOG_MAX) target_log.push_back(t);
    end else if (target_log.size() > 0 && $urandom_range(99) < 65) begin
      t     = target_log[$urandom_range(0, target_log.size() - 1)];
      r.bus = t.bus;
      r.dev = t.dev;
      r.fn  = t.fn;
      // Sometimes disturb the upper pin bits to probe the pin mask
      r.pin = ($urandom_range(3) == 0) ? (t.pin ^ (8'($urandom) & 8'hF8)) : t.pin;
    end
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: offer the oldest pending item, hold it until accepted
  always @(posedge clk) begin : driver
    route_req_t  head;
    route_resp_t resp;
    bit          offering;
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.operation       <= OP_ADD;
      in_ch.child_address   <= '0;
      in_ch.bus_number      <= '0;
      in_ch.device_number   <= '0;
      in_ch.function_number <= '0;
      in_ch.pin             <= '0;
      in_ch.irq_number      <= '0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        resp = predict_route(pending_requests[0]);
        expected_routes.push_back(resp);
        void'(pending_requests.pop_front());
        items_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_requests.size() > 0 &&
            (quiet_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
          head = pending_requests[0];
          in_ch.valid           <= 1'b1;
          in_ch.operation       <= head.operation;
          in_ch.child_address   <= head.child_address;
          in_ch.bus_number      <= head.bus;
          in_ch.device_number   <= head.dev;
          in_ch.function_number <= head.fn;
          in_ch.pin             <= head.pin;
          in_ch.irq_number      <= head.irq;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off
  always @(posedge clk) begin : receiver
    int stall_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_off_start) begin
        stall_left     = HOLD_OFF_CYCLES;
        hold_off_start = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin : monitor
    route_resp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_routes.size() == 0) begin
        $error("result with no item outstanding: accepted %0d, found_irq 0x%08h",
               out_ch.accepted, out_ch.found_irq);
        error_count++;
      end else begin
        want = expected_routes.pop_front();
        if (out_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_ch.accepted);
          error_count++;
        end
        if (out_ch.found_irq !== want.found_irq) begin
          $error("found_irq: expected 0x%08h, got 0x%08h", want.found_irq, out_ch.found_irq);
          error_count++;
        end
        if (want.accepted) adds_stored++;
        if (want.found_irq != '0) lookups_routed++;
      end
      if (out_ch.accepted === 1'b0 && out_ch.found_irq !== '0) lookups_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_count,
               expected_routes.size());
      $display("pci_intx_route_table_tb failed");
      $finish;
    end
  end

  // Write one register and mirror it into the shadow masks
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_ADDRESS_MASK) shadow_address_mask = value;
    else if (idx == REG_PIN_MASK) shadow_pin_mask = value[7:0];
  endtask

  task automatic set_masks(input logic [31:0] address_mask, input logic [7:0] pin_mask);
    write_register(REG_ADDRESS_MASK, address_mask);
    write_register(REG_PIN_MASK, {24'h0, pin_mask});
    mask_settings++;
  endtask

  // Hold until every item has been accepted and answered
  task automatic wait_idle();
    do @(negedge clk); while (pending_requests.size() != 0 || expected_routes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random(input int count, input int add_percent);
    for (int i = 0; i < count; i++) pending_requests.push_back(random_request(add_percent));
  endtask

  initial begin : stimulus
    rst_n                 = 1'b0;
    quiet_mode            = 1'b0;
    hold_off_start        = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.operation       = OP_ADD;
    in_ch.child_address   = '0;
    in_ch.bus_number      = '0;
    in_ch.device_number   = '0;
    in_ch.function_number = '0;
    in_ch.pin             = '0;
    in_ch.irq_number      = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    shadow_address_mask   = ADDRESS_MASK_RESET;
    shadow_pin_mask       = PIN_MASK_RESET;
    shadow_count          = 0;
    mask_settings         = 1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset masks
    pending_requests.push_back(make_lookup(8'h00, 5'd0, 3'd0, 8'd1));   // empty table
    pending_requests.push_back(make_add(32'h0000_0800, 8'd0, 32'd5));   // pin too low
    pending_requests.push_back(make_add(32'h0000_0800, 8'd5, 32'd5));   // pin too high
    pending_requests.push_back(make_add(32'h0000_0800, 8'hFF, 32'd5));  // pin at field max
    pending_requests.push_back(make_add(32'h0000_0800, 8'd1, 32'd0));   // zero irq
    pending_requests.push_back(make_add(32'h0000_0800, 8'd1, 32'hFFFF_FFFF));
    pending_requests.push_back(make_add(32'hFFFF_FFFF, 8'd4, 32'd1));
    pending_requests.push_back(make_add(32'h0000_0800, 8'd1, 32'h0000_1234));  // shadowed copy
    pending_requests.push_back(make_lookup(8'hFF, 5'd31, 3'd7, 8'd4));
    pending_requests.push_back(make_lookup(8'h00, 5'd1, 3'd0, 8'd1));   // first match wins
    pending_requests.push_back(make_lookup(8'h00, 5'd1, 3'd0, 8'd9));   // upper pin bits masked
    pending_requests.push_back(make_lookup(8'h00, 5'd1, 3'd0, 8'd0));
    pending_requests.push_back(make_lookup(8'h00, 5'd2, 3'd0, 8'd1));
    pending_requests.push_back(make_add(32'h0000_0000, 8'd2, 32'h8000_0000));
    pending_requests.push_back(make_lookup(8'hAA, 5'd0, 3'd5, 8'd2));
    pending_requests.push_back(make_add(32'h0000_1000, 8'd3, 32'hFFFF_FFFE));
    pending_requests.push_back(make_lookup(8'h00, 5'd2, 3'd0, 8'hFB));
    pending_requests.push_back(make_lookup(8'hFF, 5'd31, 3'd7, 8'hFF));
    wait_idle();

    // Fill the table under the reset masks, then run past full
    queue_random(300, 40);
    wait_idle();

    // Widest masks: stored entries keep their old masking
    set_masks(32'hFFFF_FFFF, 8'hFF);
    queue_random(250, 15);
    wait_idle();

    // Zero masks: every lookup key becomes zero and matches only entries stored with zero address and pin
    set_masks(32'h0000_0000, 8'h00);
    queue_random(150, 20);
    wait_idle();

    // Spare indexes must be ignored; then stall the result side for a long stretch
    write_register(REG_SPARE_LOW, 32'hDEAD_BEEF);
    write_register(REG_SPARE_HIGH, 32'h0000_0000);
    set_masks(32'h0000_F800, 8'h03);
    queue_random(250, 10);
    hold_off_start = 1'b1;
    wait_idle();

    // Back-to-back stretch with no idling on either side
    set_masks(32'h00FF_FF00, 8'h07);
    quiet_mode = 1'b1;
    queue_random(300, 10);
    wait_idle();
    quiet_mode = 1'b0;

    // Random mask settings
    for (int p = 0; p < 3; p++) begin
      set_masks(($urandom_range(1) == 0) ? $urandom : ($urandom | 32'h0000_1800),
                8'($urandom));
      queue_random(200, 10);
      wait_idle();
    end

    // Back to the reset masks
    set_masks(ADDRESS_MASK_RESET, PIN_MASK_RESET);
    queue_random(200, 10);
    wait_idle();

    $display("covered %0d items over %0d mask settings: %0d adds stored, %0d lookups routed",
             items_sent, mask_settings, adds_stored, lookups_routed);
    $display("table held %0d of %0d entries, %0d errors", shadow_count, TABLE_DEPTH,
             error_count);
    if (error_count == 0) begin
      $display("pci_intx_route_table_tb passed");
    end else begin
      $display("pci_intx_route_table_tb failed");
    end
    $finish;
  end

endmodule
